// File: rtl/canonical_prefix_compare_defines.svh
// ---------------------------------------------------------------------------
// canonical_prefix_compare_defines.svh
// Assertion macros shared by the canonical prefix compare block.
// ---------------------------------------------------------------------------
`ifndef CANONICAL_PREFIX_COMPARE_DEFINES_SVH
`define CANONICAL_PREFIX_COMPARE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("canonical_prefix_compare: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define CPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("canonical_prefix_compare: next-cycle check failed");

`endif

// File: rtl/cpc_pkg.sv
// ---------------------------------------------------------------------------
// cpc_pkg
// Types, constants and the Latin-1 fold table of the prefix compare block.
// ---------------------------------------------------------------------------
package cpc_pkg;

    // Field widths.
    localparam int RUNE_W      = 21;
    localparam int CODE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    // Default key storage depth.
    localparam int KEY_LEN_DEFAULT = 64;

    // Reset value of the separator register (horizontal tab).
    localparam logic [RUNE_W-1:0] SEP_RESET = 21'h000009;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DICT_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 2'd2;

    // Input commands.
    localparam logic CMD_KEY   = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    // Compare codes; UNDECIDED is internal only.
    localparam logic [CODE_W-1:0] CODE_KEY_BEFORE   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_KEY_PREFIX   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_EQUAL        = 3'd2;
    localparam logic [CODE_W-1:0] CODE_ENTRY_PREFIX = 3'd3;
    localparam logic [CODE_W-1:0] CODE_ENTRY_BEFORE = 3'd4;
    localparam logic [CODE_W-1:0] CODE_UNDECIDED    = 3'd7;

    // Latin-1 range that folds to plain ASCII.
    localparam logic [RUNE_W-1:0] LATIN_LO = 21'h0000C0;
    localparam logic [RUNE_W-1:0] LATIN_HI = 21'h0000FF;

    // Fold table for 0xC0..0xFF; zero means the rune is kept as it is.
    localparam logic [7:0] FOLD_TABLE [64] = '{
        "a", "a", "a", "a", "a", "a", "a", "c",
        "e", "e", "e", "e", "i", "i", "i", "i",
        "d", "n", "o", "o", "o", "o", "o", 8'h00,
        "o", "u", "u", "u", "u", "y", 8'h00, 8'h00,
        "a", "a", "a", "a", "a", "a", "a", "c",
        "e", "e", "e", "e", "i", "i", "i", "i",
        "d", "n", "o", "o", "o", "o", "o", 8'h00,
        "o", "u", "u", "u", "u", "y", 8'h00, "y"
    };

    // Configuration seen by the canonicalizer.
    typedef struct packed {
        logic              fold_case;
        logic              dict_order;
        logic [RUNE_W-1:0] separator;
    } cfg_t;

    // What canonicalization makes of one rune.
    typedef enum logic [1:0] {
        CANON_KEEP,
        CANON_DROP,
        CANON_END
    } canon_kind_t;

    typedef struct packed {
        canon_kind_t       kind;
        logic [RUNE_W-1:0] rune;
    } canon_t;

endpackage

// File: rtl/canonical_prefix_compare.sv
// ---------------------------------------------------------------------------
// canonical_prefix_compare
// Stores a canonical search key and compares dictionary entries against it.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one rune per beat: s_tuser selects key (0) or
//   dictionary entry (1), s_tlast marks the final rune of a word. Key runes
//   are canonicalized and stored; entry runes are compared against the key.
//   The last rune of an entry yields one beat on the m_ channel with the
//   compare code in m_tdata and the key-truncated flag in m_tuser. All other
//   beats yield nothing. The cfg_ channel writes fold_case (0),
//   dictionary_order (1) and separator_rune (2); it is always ready, and
//   the user must write it only while idle, unchecked by the block itself.
// Timing:
//   One rune per cycle sustained while the receiver takes results. A rune
//   is captured in the input register and its result in the output
//   register. The key RAM read address is the next match position, so the
//   key rune is ready when the entry rune is.
// Reset and stall:
//   Reset empties the key and the entry and restores the register defaults.
//   While m_tready is low with a result waiting, the input stage holds and
//   s_tready falls once the input register is full.
// ---------------------------------------------------------------------------
`include "canonical_prefix_compare_defines.svh"

module canonical_prefix_compare #(
    parameter int KEY_LEN = cpc_pkg::KEY_LEN_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input beats. tdata: rune_value[20:0]; tuser: command; tlast: is_last.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cpc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    // Result beats. tdata: compare_code[2:0]; tuser: key_truncated.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cpc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpc_pkg::RUNE_W-1:0]      cfg_data
);
    import cpc_pkg::*;

    localparam int AW  = $clog2(KEY_LEN);
    localparam int KLW = $clog2(KEY_LEN + 1);

    // Configuration registers.
    logic              fold_case_reg;
    logic              dict_order_reg;
    logic [RUNE_W-1:0] separator_reg;
    cfg_t              cfg;

    // Input register.
    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [RUNE_W-1:0] in_rune_reg;
    logic              in_last_reg;

    // Key and entry state.
    logic [KLW-1:0]    key_length_reg, key_length_next;
    logic [KLW-1:0]    match_position_reg, match_position_next;
    logic [CODE_W-1:0] decision_reg, decision_next;
    logic              entry_ended_reg, entry_ended_next;
    logic              key_ended_reg, key_ended_next;
    logic              key_complete_reg, key_complete_next;
    logic              key_overflow_reg, key_overflow_next;

    // Key RAM and write bypass.
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [RUNE_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [RUNE_W-1:0] rd_data;
    logic              byp_hit_reg;
    logic [RUNE_W-1:0] byp_data_reg;
    logic [RUNE_W-1:0] key_word;

    // Output register.
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_trunc_reg;

    logic              advance;
    logic              res_fire;
    logic [CODE_W-1:0] res_code;
    canon_t            canon;

    // Configuration port.
    assign cfg_ready = 1'b1;
    assign cfg.fold_case  = fold_case_reg;
    assign cfg.dict_order = dict_order_reg;
    assign cfg.separator  = separator_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_case_reg  <= 1'b0;
            dict_order_reg <= 1'b0;
            separator_reg  <= SEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FOLD_CASE:  fold_case_reg  <= cfg_data[0];
                CFG_DICT_ORDER: dict_order_reg <= cfg_data[0];
                CFG_SEPARATOR:  separator_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The stage moves when the output register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_rune_reg <= s_tdata[RUNE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    cpc_canon u_canon (
        .rune_in (in_rune_reg),
        .cfg     (cfg),
        .canon   (canon)
    );

    // Key store; the read address always follows the next match position.
    cpc_ram #(
        .WIDTH (RUNE_W),
        .DEPTH (KEY_LEN)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_addr  = match_position_next[AW-1:0];
    assign key_word = byp_hit_reg ? byp_data_reg : rd_data;

    // A key rune written in the cycle its address is read is forwarded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
        byp_data_reg <= wr_data;
    end

    // Key capture and entry compare for the rune in the input register.
    always_comb begin
        key_length_next     = key_length_reg;
        match_position_next = match_position_reg;
        decision_next       = decision_reg;
        entry_ended_next    = entry_ended_reg;
        key_ended_next      = key_ended_reg;
        key_complete_next   = key_complete_reg;
        key_overflow_next   = key_overflow_reg;
        wr_en               = 1'b0;
        wr_addr             = key_length_reg[AW-1:0];
        wr_data             = canon.rune;
        res_fire            = 1'b0;
        res_code            = decision_reg;
        if (advance) begin
            if (in_cmd_reg == CMD_KEY) begin
                // A rune after a finished key starts a new one.
                if (key_complete_reg) begin
                    key_length_next   = '0;
                    key_ended_next    = 1'b0;
                    key_overflow_next = 1'b0;
                end
                // Any key rune abandons the entry in progress.
                match_position_next = '0;
                decision_next       = CODE_UNDECIDED;
                entry_ended_next    = 1'b0;
                if (!key_ended_next) begin
                    if (canon.kind == CANON_END) begin
                        key_ended_next = 1'b1;
                    end else if (canon.kind == CANON_KEEP) begin
                        if (key_length_next < KLW'(KEY_LEN)) begin
                            wr_en           = 1'b1;
                            wr_addr         = key_length_next[AW-1:0];
                            key_length_next = key_length_next + KLW'(1);
                        end else begin
                            key_overflow_next = 1'b1;
                        end
                    end
                end
                key_complete_next = in_last_reg;
            end else begin
                if (!entry_ended_reg) begin
                    if (canon.kind == CANON_END) begin
                        entry_ended_next = 1'b1;
                    end else if ((canon.kind == CANON_KEEP) &&
                                 (decision_reg == CODE_UNDECIDED)) begin
                        if (match_position_reg < key_length_reg) begin
                            if (key_word == canon.rune) begin
                                match_position_next = match_position_reg + KLW'(1);
                            end else if (key_word < canon.rune) begin
                                decision_next = CODE_KEY_BEFORE;
                            end else begin
                                decision_next = CODE_ENTRY_BEFORE;
                            end
                        end else begin
                            decision_next = CODE_KEY_PREFIX;
                        end
                    end
                end
                // The last entry rune settles the code and clears the entry.
                if (in_last_reg) begin
                    res_fire = 1'b1;
                    if (decision_next == CODE_UNDECIDED) begin
                        res_code = (match_position_next >= key_length_reg) ?
                                   CODE_EQUAL : CODE_ENTRY_PREFIX;
                    end else begin
                        res_code = decision_next;
                    end
                    match_position_next = '0;
                    decision_next       = CODE_UNDECIDED;
                    entry_ended_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg     <= '0;
            match_position_reg <= '0;
            decision_reg       <= CODE_UNDECIDED;
            entry_ended_reg    <= 1'b0;
            key_ended_reg      <= 1'b0;
            key_complete_reg   <= 1'b1;
            key_overflow_reg   <= 1'b0;
        end else begin
            key_length_reg     <= key_length_next;
            match_position_reg <= match_position_next;
            decision_reg       <= decision_next;
            entry_ended_reg    <= entry_ended_next;
            key_ended_reg      <= key_ended_next;
            key_complete_reg   <= key_complete_next;
            key_overflow_reg   <= key_overflow_next;
        end
    end

    // Output register holds a result until the receiver takes the beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            out_code_reg  <= res_code;
            out_trunc_reg <= key_overflow_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-CODE_W){1'b0}}, out_code_reg};
    assign m_tuser  = out_trunc_reg;

    // Consistency of the key and entry state.
    `CPC_ASSERT_IMPL(a_key_len_bound, 1'b1, key_length_reg <= KLW'(KEY_LEN))
    `CPC_ASSERT_IMPL(a_match_in_key, 1'b1, match_position_reg <= key_length_reg)
    `CPC_ASSERT_IMPL(a_overflow_full, key_overflow_reg, key_length_reg == KLW'(KEY_LEN))
    `CPC_ASSERT_NEXT(a_result_shown, res_fire, m_tvalid)

endmodule

// File: rtl/cpc_ram.sv
// ---------------------------------------------------------------------------
// cpc_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ---------------------------------------------------------------------------
module cpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the written address returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/cpc_canon.sv
// ---------------------------------------------------------------------------
// cpc_canon
// Canonicalizes one rune: word end, Latin-1 fold, dictionary filter, case fold.
// ---------------------------------------------------------------------------
module cpc_canon (
    input  logic [cpc_pkg::RUNE_W-1:0] rune_in,
    input  cpc_pkg::cfg_t              cfg,
    output cpc_pkg::canon_t            canon
);
    import cpc_pkg::*;

    logic [RUNE_W-1:0] folded;
    logic [7:0]        table_char;
    logic              keep;

    // Latin-1 lookup; the table index is the low six bits of the rune.
    assign table_char = FOLD_TABLE[rune_in[5:0]];

    always_comb begin
        folded = rune_in;
        if ((rune_in >= LATIN_LO) && (rune_in <= LATIN_HI) && (table_char != 8'h00)) begin
            folded = {{(RUNE_W-8){1'b0}}, table_char};
        end
    end

    // Letters, digits, space and tab survive dictionary mode.
    assign keep = folded inside {[21'h000061:21'h00007A], [21'h000041:21'h00005A],
                                 [21'h000030:21'h000039], 21'h000020, 21'h000009};

    always_comb begin
        canon.kind = CANON_KEEP;
        canon.rune = folded;
        if ((rune_in == '0) || (rune_in == cfg.separator)) begin
            canon.kind = CANON_END;
        end else if (cfg.dict_order && !keep) begin
            canon.kind = CANON_DROP;
        end else if (cfg.fold_case && (folded inside {[21'h000041:21'h00005A]})) begin
            canon.rune = folded + 21'h000020;
        end
    end

endmodule

// File: bench/canonical_prefix_compare_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// canonical_prefix_compare_tb
// Self-checking bench for the canonical prefix compare block. Key and entry
// runes are streamed in, and each entry verdict is predicted by an in-bench
// canonicalizer and comparator. Predicted verdicts are checked in order
// against the result beats, under several register settings and several
// patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module canonical_prefix_compare_tb;
    import cpc_pkg::*;

    localparam int KEY_LEN       = KEY_LEN_DEFAULT;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;

    typedef logic [RUNE_W-1:0] rune_q_t[$];

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              truncated;
    } verdict_t;

    // Clock, reset and block ports.
    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = CMD_KEY;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_FOLD_CASE;
    logic [RUNE_W-1:0]      cfg_data  = '0;

    // Traffic shaping shared by the sender, the receiver and the tests.
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int items_sent = 0;
    int mismatch_count = 0;

    // Predictor copy of the registers.
    logic              fold_on  = 1'b0;
    logic              dict_on  = 1'b0;
    logic [RUNE_W-1:0] sep_rune = SEP_RESET;

    // Predictor copy of the key and entry state.
    logic [RUNE_W-1:0] key_runes [KEY_LEN];
    int                key_count    = 0;
    int                matched      = 0;
    logic [CODE_W-1:0] verdict      = CODE_UNDECIDED;
    logic              entry_closed = 1'b0;
    logic              key_closed   = 1'b0;
    logic              key_done     = 1'b1;
    logic              key_cut      = 1'b0;

    verdict_t expected_verdicts[$];
    rune_q_t  key_text;

    canonical_prefix_compare #(.KEY_LEN(KEY_LEN)) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void flag_error(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch in %0s: expected 0x%0h, got 0x%0h", what, want, got);
    endfunction

    // Latin-1 0xC0..0xFF to plain ASCII letter; zero keeps the rune unchanged.
    function automatic logic [7:0] latin_fold(logic [5:0] idx);
        logic [4:0] low;
        low = idx[4:0];
        if (idx == 6'd63) return "y";
        if (low <= 5'd6) return "a";
        if (low == 5'd7) return "c";
        if (low <= 5'd11) return "e";
        if (low <= 5'd15) return "i";
        if (low == 5'd16) return "d";
        if (low == 5'd17) return "n";
        if (low <= 5'd22) return "o";
        if (low == 5'd23) return 8'h00;
        if (low == 5'd24) return "o";
        if (low <= 5'd28) return "u";
        if (low == 5'd29) return "y";
        return 8'h00;
    endfunction

    function automatic canon_t canonicalize_rune(logic [RUNE_W-1:0] rune);
        canon_t res;
        logic [RUNE_W-1:0] c;
        logic keep;
        c = rune;
        res.kind = CANON_KEEP;
        res.rune = c;
        if (c == '0 || c == sep_rune) begin
            res.kind = CANON_END;
            return res;
        end
        if (c >= LATIN_LO && c <= LATIN_HI && latin_fold(c[5:0]) != 8'h00)
            c = {{(RUNE_W-8){1'b0}}, latin_fold(c[5:0])};
        if (dict_on) begin
            keep = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || c == " " || c == "\t";
            if (!keep) begin
                res.kind = CANON_DROP;
                return res;
            end
        end
        if (fold_on && c >= "A" && c <= "Z")
            c = c + RUNE_W'("a" - "A");
        res.rune = c;
        return res;
    endfunction

    // Advance the predicted state by one accepted beat.
    function automatic void predict_beat(logic cmd, logic [RUNE_W-1:0] rune, logic is_final);
        canon_t   c;
        verdict_t v;
        if (cmd == CMD_KEY) begin
            if (key_done) begin
                key_count  = 0;
                key_closed = 1'b0;
                key_cut    = 1'b0;
                key_done   = 1'b0;
            end
            // Any key rune abandons the entry in progress.
            matched      = 0;
            verdict      = CODE_UNDECIDED;
            entry_closed = 1'b0;
            if (!key_closed) begin
                c = canonicalize_rune(rune);
                if (c.kind == CANON_END) begin
                    key_closed = 1'b1;
                end else if (c.kind == CANON_KEEP) begin
                    if (key_count < KEY_LEN) begin
                        key_runes[key_count] = c.rune;
                        key_count++;
                    end else begin
                        key_cut = 1'b1;
                    end
                end
            end
            if (is_final)
                key_done = 1'b1;
            return;
        end

        if (!entry_closed) begin
            c = canonicalize_rune(rune);
            if (c.kind == CANON_END) begin
                entry_closed = 1'b1;
            end else if (c.kind == CANON_KEEP && verdict == CODE_UNDECIDED) begin
                if (matched < key_count) begin
                    if (key_runes[matched] == c.rune)
                        matched++;
                    else
                        verdict = (key_runes[matched] < c.rune) ? CODE_KEY_BEFORE
                                                                : CODE_ENTRY_BEFORE;
                end else begin
                    verdict = CODE_KEY_PREFIX;
                end
            end
        end
        if (is_final) begin
            if (verdict != CODE_UNDECIDED)
                v.code = verdict;
            else
                v.code = (matched >= key_count) ? CODE_EQUAL : CODE_ENTRY_PREFIX;
            v.truncated = key_cut;
            expected_verdicts.push_back(v);
            matched      = 0;
            verdict      = CODE_UNDECIDED;
            entry_closed = 1'b0;
        end
    endfunction

    // Receiver: random stalls, or a counted hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: each result beat against the oldest predicted verdict.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                flag_error("result beat with none expected", 0, m_tdata);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata !== {{(OUT_TDATA_W-CODE_W){1'b0}}, want.code})
                    flag_error("compare code", want.code, m_tdata);
                if (m_tuser !== want.truncated)
                    flag_error("key truncated flag", want.truncated, m_tuser);
            end
        end
    end

    // Offer one rune beat, with random gaps before it, and wait for acceptance.
    task automatic send_rune(input logic cmd, input logic [RUNE_W-1:0] rune,
                             input logic is_final);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_TDATA_W-RUNE_W){1'b0}}, rune};
        s_tlast  <= is_final;
        do @(posedge aclk); while (!s_tready);
        predict_beat(cmd, rune, is_final);
        items_sent++;
    endtask

    task automatic send_word(input logic cmd, input rune_q_t runes, input logic is_final);
        for (int i = 0; i < runes.size(); i++)
            send_rune(cmd, runes[i], is_final && (i == runes.size() - 1));
    endtask

    task automatic send_text(input logic cmd, input string text);
        for (int i = 0; i < text.len(); i++)
            send_rune(cmd, RUNE_W'(text[i]), i == text.len() - 1);
    endtask

    // Stop offering, wait for every predicted verdict, then let the pipe settle.
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (expected_verdicts.size() != 0) begin
            flag_error("results never delivered", 0, expected_verdicts.size());
            expected_verdicts.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back; only called while idle.
    task automatic load_config(input logic fold, input logic dict,
                               input logic [RUNE_W-1:0] sep);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [RUNE_W-1:0]    val [3];
        idx[0] = CFG_FOLD_CASE;  val[0] = {{(RUNE_W-1){1'b0}}, fold};
        idx[1] = CFG_DICT_ORDER; val[1] = {{(RUNE_W-1){1'b0}}, dict};
        idx[2] = CFG_SEPARATOR;  val[2] = sep;
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        fold_on  = fold;
        dict_on  = dict;
        sep_rune = sep;
    endtask

    // Rune mix weighted toward a small alphabet so that words often match.
    function automatic logic [RUNE_W-1:0] random_rune();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return RUNE_W'("a" + $urandom_range(3));
        if (pick < 50) return RUNE_W'("A" + $urandom_range(3));
        if (pick < 56) return RUNE_W'("0" + $urandom_range(9));
        if (pick < 60) return RUNE_W'($urandom_range(1) ? " " : "\t");
        if (pick < 70) return RUNE_W'(LATIN_LO + $urandom_range(63));
        if (pick < 77) return RUNE_W'($urandom_range(8'h7E, 8'h21));
        if (pick < 79) return '0;
        if (pick < 82) return sep_rune;
        if (pick < 88) return RUNE_W'(21'h1FFFFF - $urandom_range(255));
        return RUNE_W'($urandom_range(21'h1FFFFF));
    endfunction

    function automatic rune_q_t make_key();
        rune_q_t word;
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 85) len = $urandom_range(8, 1);
        else if (pick < 95) len = $urandom_range(40, 9);
        else len = $urandom_range(70, 60);
        for (int i = 0; i < len; i++)
            word.push_back(random_rune());
        return word;
    endfunction

    // Entries are mostly the key text, cut, extended or altered.
    function automatic rune_q_t make_entry();
        rune_q_t word;
        int len;
        if ($urandom_range(99) < 65) begin
            word = key_text;
            if (word.size() > 0 && $urandom_range(99) < 30) begin
                len = $urandom_range(word.size());
                while (word.size() > len) void'(word.pop_back());
            end
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(2, 1)) word.push_back(random_rune());
            if (word.size() > 0 && $urandom_range(99) < 30)
                word[$urandom_range(word.size() - 1)] = random_rune();
        end
        if (word.size() == 0) begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
                word.push_back(random_rune());
        end
        return word;
    endfunction

    // An empty key is a prefix of any entry; an empty entry equals it.
    task automatic test_empty_key();
        send_text(CMD_ENTRY, "a");
        send_rune(CMD_ENTRY, '0, 1'b1);
        wait_for_drain();
    endtask

    // Every compare code against a two-rune key.
    task automatic test_compare_codes();
        send_text(CMD_KEY, "bd");
        send_text(CMD_ENTRY, "bd");
        send_text(CMD_ENTRY, "bda");
        send_text(CMD_ENTRY, "b");
        send_text(CMD_ENTRY, "be");
        send_text(CMD_ENTRY, "a");
        wait_for_drain();
    endtask

    // Latin-1 folding, unfolded Latin-1, the widest rune and the separator.
    task automatic test_word_end_and_folding();
        send_rune(CMD_KEY, LATIN_LO, 1'b0);
        send_rune(CMD_KEY, 21'h1FFFFF, 1'b1);
        send_rune(CMD_ENTRY, RUNE_W'("a"), 1'b0);
        send_rune(CMD_ENTRY, 21'h1FFFFF, 1'b1);
        send_rune(CMD_ENTRY, 21'h0000E0, 1'b0);
        send_rune(CMD_ENTRY, 21'h1FFFFF, 1'b0);
        send_rune(CMD_ENTRY, SEP_RESET, 1'b0);
        send_rune(CMD_ENTRY, RUNE_W'("q"), 1'b1);
        send_rune(CMD_ENTRY, 21'h0000D7, 1'b1);
        wait_for_drain();
    endtask

    // A key rune drops an open entry; an entry may come before the key ends.
    task automatic test_abandon_and_partial_key();
        send_rune(CMD_ENTRY, RUNE_W'("x"), 1'b0);
        send_rune(CMD_KEY, RUNE_W'("c"), 1'b0);
        send_rune(CMD_ENTRY, RUNE_W'("c"), 1'b1);
        send_rune(CMD_KEY, RUNE_W'("d"), 1'b1);
        send_text(CMD_ENTRY, "cd");
        wait_for_drain();
    endtask

    // A key longer than the store is cut and reported as truncated.
    task automatic test_key_overflow();
        rune_q_t word;
        for (int i = 0; i < KEY_LEN + 2; i++)
            word.push_back(RUNE_W'("a" + $urandom_range(2)));
        key_text = word;
        send_word(CMD_KEY, word, 1'b1);
        send_word(CMD_ENTRY, word, 1'b1);
        void'(word.pop_back());
        void'(word.pop_back());
        send_word(CMD_ENTRY, word, 1'b1);
        send_text(CMD_KEY, "b");
        send_text(CMD_ENTRY, "b");
        wait_for_drain();
    endtask

    // Hold the receiver off while entries keep coming, so the input stalls.
    task automatic test_stall_pressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 120;
        for (int i = 0; i < 30; i++)
            send_rune(CMD_ENTRY, RUNE_W'("a" + $urandom_range(3)), 1'b1);
        wait_for_drain();
    endtask

    // Random words across register settings and traffic patterns.
    task automatic test_random_traffic();
        int start;
        int phase;
        int pick;
        rune_q_t word;
        rune_q_t rest;
        int idle_tab [4];
        int stall_tab [4];
        idle_tab  = '{0, 77, 0, 37};
        stall_tab = '{0, 0, 77, 37};
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            wait_for_drain();
            idle_pct  = idle_tab[phase % 4];
            stall_pct = stall_tab[phase % 4];
            case (phase)
                0: load_config(1'b0, 1'b0, SEP_RESET);
                1: load_config(1'b1, 1'b0, RUNE_W'(" "));
                2: load_config(1'b0, 1'b1, '0);
                3: load_config(1'b1, 1'b1, 21'h1FFFFF);
                default: begin
                    pick = $urandom_range(2);
                    load_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                                pick == 0 ? SEP_RESET :
                                pick == 1 ? RUNE_W'("a" + $urandom_range(3)) :
                                            RUNE_W'($urandom_range(21'h1FFFFF)));
                end
            endcase
            while (items_sent - start < (phase + 1) * RANDOM_ITEMS / PHASES) begin
                pick = $urandom_range(99);
                if (pick < 18) begin
                    word = make_key();
                    key_text = word;
                    send_word(CMD_KEY, word, 1'b1);
                end else if (pick < 22) begin
                    // Entry cut short by a new key.
                    send_word(CMD_ENTRY, make_entry(), 1'b0);
                    word = make_key();
                    key_text = word;
                    send_word(CMD_KEY, word, 1'b1);
                end else if (pick < 26) begin
                    // Key split by an entry compared against its first part.
                    word = make_key();
                    rest = make_key();
                    send_word(CMD_KEY, word, 1'b0);
                    send_word(CMD_ENTRY, make_entry(), 1'b1);
                    send_word(CMD_KEY, rest, 1'b1);
                    key_text = {word, rest};
                end else begin
                    send_word(CMD_ENTRY, make_entry(), 1'b1);
                end
            end
            phase++;
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_key();
        test_compare_codes();
        test_word_end_and_folding();
        test_abandon_and_partial_key();
        test_key_overflow();
        test_stall_pressure();
        test_random_traffic();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: canonical_prefix_compare.f
+incdir+rtl
rtl/cpc_pkg.sv
rtl/cpc_ram.sv
rtl/cpc_canon.sv
rtl/canonical_prefix_compare.sv
bench/canonical_prefix_compare_tb.sv
